// ===== rtl/ksa_pkg.sv =====
// Shared constants, codes and beat types of the keyed slot allocator.
// No dependencies; the top level and the bench refer to this package.
`timescale 1ns / 1ps
`default_nettype none

package ksa_pkg;

    // Built pool depth and owner key width
    localparam int POOL_DEPTH = 16;
    localparam int KEY_WIDTH  = 32;

    // Derived widths
    localparam int IDX_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W     = $clog2(POOL_DEPTH + 1);
    localparam int MAX_OUT   = 16;
    localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);

    // Fixed field widths
    localparam int CFG_W  = 5;
    localparam int ACT_W  = 3;
    localparam int SLOT_W = 4;

    // Request actions
    localparam logic [ACT_W-1:0] ACT_ACQUIRE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MARK    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SWEEP   = 3'd4;

    // Result kinds
    localparam logic [ACT_W-1:0] KIND_ACQUIRE = 3'd0;
    localparam logic [ACT_W-1:0] KIND_RELEASE = 3'd1;
    localparam logic [ACT_W-1:0] KIND_QUERY   = 3'd2;
    localparam logic [ACT_W-1:0] KIND_EVICT   = 3'd3;
    localparam logic [ACT_W-1:0] KIND_DONE    = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0]     action;
        logic [KEY_WIDTH-1:0] entity_key;
        logic                 last;
    } t_in_beat;

    typedef struct packed {
        logic [ACT_W-1:0]     kind;
        logic                 ok;
        logic [SLOT_W-1:0]    slot;
        logic [KEY_WIDTH-1:0] evicted_key;
        logic                 last_res;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== rtl/ksa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the slot owner store.
`timescale 1ns / 1ps
`default_nettype none

module ksa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/keyed_slot_allocator_unit.sv =====
// Top level of the keyed slot allocator: sequencer, slot flags, owner RAM.
// Depends on ksa_pkg and ksa_ram.
//
// Keyed slot pool with one owner RAM read port that a sequencer walks one slot per cycle
// while no sweep is held. An item is taken when the block is idle; it then scans slots 0
// up to the active pool size (min of pool_size and the built depth), stopping early on a
// key hit, and then commits and loads the result. The last key of a reconcile list, or an
// empty list, adds a sweep over the active slots, and the commit and each eviction wait for
// the result register when the consumer stalls. A pool_size write clears all valid and
// mark flags in the same cycle; no clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module keyed_slot_allocator_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [ksa_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire ksa_pkg::t_in_beat          i_in_beat,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output ksa_pkg::t_out_beat              o_out_beat
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_SWEND = 3'd4;

    // Control state
    logic [2:0]                       r_state, n_state;
    logic [ksa_pkg::CFG_W-1:0]        r_pool_size, n_pool_size;
    logic [ksa_pkg::POOL_DEPTH-1:0]   r_valid, n_valid;
    logic [ksa_pkg::POOL_DEPTH-1:0]   r_marked, n_marked;
    logic                             r_hit_vld, n_hit_vld;
    logic                             r_free_vld, n_free_vld;
    logic                             r_pend_vld, n_pend_vld;
    logic                             r_out_vld, n_out_vld;
    logic [ksa_pkg::OUT_CNT_W-1:0]    r_cnt, n_cnt;

    // Payload
    logic [ksa_pkg::ACT_W-1:0]        r_action, n_action;
    logic [ksa_pkg::KEY_WIDTH-1:0]    r_key, n_key;
    logic                             r_last, n_last;
    logic [ksa_pkg::IDX_W-1:0]        r_idx, n_idx;
    logic [ksa_pkg::IDX_W-1:0]        r_hit_idx, n_hit_idx;
    logic [ksa_pkg::IDX_W-1:0]        r_free_idx, n_free_idx;
    logic [ksa_pkg::IDX_W-1:0]        r_pend_idx, n_pend_idx;
    logic [ksa_pkg::KEY_WIDTH-1:0]    r_pend_key, n_pend_key;
    ksa_pkg::t_out_beat               r_out, n_out;

    // Datapath
    logic [ksa_pkg::CNT_W-1:0]        w_active;
    logic                             w_idx_end;
    logic                             w_out_free;
    logic                             w_hit;
    logic                             w_evict;
    logic                             w_adv;
    logic                             w_ram_we;
    logic [ksa_pkg::KEY_WIDTH-1:0]    w_rdata;

    assign w_active = (32'(r_pool_size) > ksa_pkg::POOL_DEPTH) ?
                      ksa_pkg::CNT_W'(ksa_pkg::POOL_DEPTH) :
                      ksa_pkg::CNT_W'(r_pool_size);
    assign w_idx_end  = ((ksa_pkg::CNT_W'(r_idx) + ksa_pkg::CNT_W'(1)) == w_active);
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_hit      = r_valid[r_idx] && (w_rdata == r_key);
    assign w_evict    = r_valid[r_idx] && !r_marked[r_idx] &&
                        (r_cnt < ksa_pkg::OUT_CNT_W'(ksa_pkg::MAX_OUT));
    // Hold the sweep when a new eviction would overwrite a pending one that cannot leave
    assign w_adv      = !(w_evict && r_pend_vld && !w_out_free);

    // Read address is the next index, so read data lines up with r_idx
    ksa_ram #(
        .WIDTH (ksa_pkg::KEY_WIDTH),
        .DEPTH (ksa_pkg::POOL_DEPTH)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_free_idx),
        .i_wdata (r_key),
        .i_raddr (n_idx),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_pool_size = r_pool_size;
        n_valid     = r_valid;
        n_marked    = r_marked;
        n_hit_vld   = r_hit_vld;
        n_free_vld  = r_free_vld;
        n_pend_vld  = r_pend_vld;
        n_out_vld   = r_out_vld && i_out_stall;
        n_cnt       = r_cnt;
        n_action    = r_action;
        n_key       = r_key;
        n_last      = r_last;
        n_idx       = r_idx;
        n_hit_idx   = r_hit_idx;
        n_free_idx  = r_free_idx;
        n_pend_idx  = r_pend_idx;
        n_pend_key  = r_pend_key;
        n_out       = r_out;
        w_ram_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_action   = i_in_beat.action;
                    n_key      = i_in_beat.entity_key;
                    n_last     = i_in_beat.last;
                    n_idx      = '0;
                    n_hit_vld  = 1'b0;
                    n_free_vld = 1'b0;
                    n_pend_vld = 1'b0;
                    n_cnt      = '0;
                    case (i_in_beat.action)
                        ksa_pkg::ACT_ACQUIRE, ksa_pkg::ACT_RELEASE,
                        ksa_pkg::ACT_QUERY, ksa_pkg::ACT_MARK: begin
                            n_state = (w_active == '0) ? S_APPLY : S_SCAN;
                        end
                        ksa_pkg::ACT_SWEEP: begin
                            n_state = (w_active == '0) ? S_SWEND : S_SWEEP;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (!r_valid[r_idx] && !r_free_vld) begin
                    n_free_vld = 1'b1;
                    n_free_idx = r_idx;
                end
                if (w_hit) begin
                    n_hit_vld = 1'b1;
                    n_hit_idx = r_idx;
                    n_state   = S_APPLY;
                end else if (w_idx_end) begin
                    n_state = S_APPLY;
                end else begin
                    n_idx = r_idx + ksa_pkg::IDX_W'(1);
                end
            end

            S_APPLY: begin
                n_out.evicted_key = '0;
                n_out.last_res    = 1'b0;
                n_out.ok          = 1'b0;
                n_out.slot        = '0;
                case (r_action)
                    ksa_pkg::ACT_MARK: begin
                        n_out = r_out;
                        if (r_hit_vld) begin
                            n_marked[r_hit_idx] = 1'b1;
                        end
                        if (r_last) begin
                            n_idx   = '0;
                            n_state = (w_active == '0) ? S_SWEND : S_SWEEP;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    ksa_pkg::ACT_ACQUIRE: begin
                        n_out.kind = ksa_pkg::KIND_ACQUIRE;
                        if (r_hit_vld) begin
                            n_out.ok   = 1'b1;
                            n_out.slot = ksa_pkg::SLOT_W'(r_hit_idx);
                        end else if (r_free_vld) begin
                            n_out.ok   = 1'b1;
                            n_out.slot = ksa_pkg::SLOT_W'(r_free_idx);
                        end
                        if (w_out_free) begin
                            if (!r_hit_vld && r_free_vld) begin
                                w_ram_we             = 1'b1;
                                n_valid[r_free_idx]  = 1'b1;
                                n_marked[r_free_idx] = 1'b0;
                            end
                            n_out_vld = 1'b1;
                            n_state   = S_IDLE;
                        end else begin
                            n_out = r_out;
                        end
                    end
                    ksa_pkg::ACT_RELEASE, ksa_pkg::ACT_QUERY: begin
                        n_out.kind = (r_action == ksa_pkg::ACT_RELEASE) ?
                                     ksa_pkg::KIND_RELEASE : ksa_pkg::KIND_QUERY;
                        if (r_hit_vld) begin
                            n_out.ok   = 1'b1;
                            n_out.slot = ksa_pkg::SLOT_W'(r_hit_idx);
                        end
                        if (w_out_free) begin
                            if (r_hit_vld && (r_action == ksa_pkg::ACT_RELEASE)) begin
                                n_valid[r_hit_idx]  = 1'b0;
                                n_marked[r_hit_idx] = 1'b0;
                            end
                            n_out_vld = 1'b1;
                            n_state   = S_IDLE;
                        end else begin
                            n_out = r_out;
                        end
                    end
                    default: begin
                        n_out   = r_out;
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_SWEEP: begin
                if (w_evict && w_adv) begin
                    if (r_pend_vld) begin
                        n_out_vld         = 1'b1;
                        n_out.kind        = ksa_pkg::KIND_EVICT;
                        n_out.ok          = 1'b0;
                        n_out.slot        = ksa_pkg::SLOT_W'(r_pend_idx);
                        n_out.evicted_key = r_pend_key;
                        n_out.last_res    = 1'b0;
                    end
                    n_pend_vld     = 1'b1;
                    n_pend_idx     = r_idx;
                    n_pend_key     = w_rdata;
                    n_valid[r_idx] = 1'b0;
                    n_cnt          = r_cnt + ksa_pkg::OUT_CNT_W'(1);
                end
                if (w_adv) begin
                    if (w_idx_end) begin
                        n_state = S_SWEND;
                    end else begin
                        n_idx = r_idx + ksa_pkg::IDX_W'(1);
                    end
                end
            end

            S_SWEND: begin
                n_marked = '0;
                if (w_out_free) begin
                    n_out_vld      = 1'b1;
                    n_out.ok       = 1'b0;
                    n_out.last_res = 1'b1;
                    if (r_pend_vld) begin
                        n_out.kind        = ksa_pkg::KIND_EVICT;
                        n_out.slot        = ksa_pkg::SLOT_W'(r_pend_idx);
                        n_out.evicted_key = r_pend_key;
                    end else begin
                        n_out.kind        = ksa_pkg::KIND_DONE;
                        n_out.slot        = '0;
                        n_out.evicted_key = '0;
                    end
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Pool size write re-initializes the flags
        if (i_cfg_we) begin
            n_pool_size = i_cfg_data;
            n_valid     = '0;
            n_marked    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pool_size <= '0;
            r_valid     <= '0;
            r_marked    <= '0;
            r_hit_vld   <= 1'b0;
            r_free_vld  <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_pool_size <= n_pool_size;
            r_valid     <= n_valid;
            r_marked    <= n_marked;
            r_hit_vld   <= n_hit_vld;
            r_free_vld  <= n_free_vld;
            r_pend_vld  <= n_pend_vld;
            r_out_vld   <= n_out_vld;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_key      <= n_key;
        r_last     <= n_last;
        r_idx      <= n_idx;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_pend_idx <= n_pend_idx;
        r_pend_key <= n_pend_key;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

    // A pending eviction exists only inside a sweep
    a_pend_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> (r_state == S_SWEEP || r_state == S_SWEND))
        else $error("pending eviction outside sweep");

    // Evictions never exceed the per-sweep cap
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ksa_pkg::OUT_CNT_W'(ksa_pkg::MAX_OUT))
        else $error("eviction count above cap");

    // Sweep completion presents a beat marked last
    a_sweep_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEND && w_out_free && !i_cfg_we) |=>
            (o_out_valid && o_out_beat.last_res))
        else $error("sweep ended without a last beat");

    // A recorded hit still points at a live slot when it is applied
    a_hit_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && r_hit_vld && !$past(i_cfg_we)) |-> r_valid[r_hit_idx])
        else $error("hit on an invalid slot");

    // Scan index stays inside the active pool
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_SWEEP) |-> (ksa_pkg::CNT_W'(r_idx) < w_active))
        else $error("scan index beyond active pool");

endmodule

`default_nettype wire

// ===== tb/tb_keyed_slot_allocator_unit.sv =====
// Self-checking bench for keyed_slot_allocator_unit: a directed table, then random phases
// over several pool sizes, every response beat checked against the table or an in-bench slot pool model.
// Depends on ksa_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_keyed_slot_allocator_unit;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 48;
    localparam int PHASE_ITEMS  = 31;
    localparam int N_PHASES     = 6;
    localparam int KEY_SET      = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int N_PLAN       = 26;
    localparam int KEY_W        = ksa_pkg::KEY_WIDTH;

    // Actions the block ignores
    localparam logic [ksa_pkg::ACT_W-1:0] ACT_RSVD_A = 3'd5;
    localparam logic [ksa_pkg::ACT_W-1:0] ACT_RSVD_B = 3'd6;
    localparam logic [ksa_pkg::ACT_W-1:0] ACT_RSVD_C = 3'd7;

    // The last entry is replaced by a random size
    localparam logic [ksa_pkg::CFG_W-1:0] PHASE_SIZES [N_PHASES] =
        '{5'd16, 5'd31, 5'd1, 5'd4, 5'd9, 5'd0};

    typedef struct packed {
        logic                      set_size;
        logic [ksa_pkg::CFG_W-1:0] size;
        ksa_pkg::t_in_beat         req;
        logic                      typed;
        ksa_pkg::t_out_beat        want;
    } t_plan_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [ksa_pkg::CFG_W-1:0] i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    ksa_pkg::t_in_beat         i_in_beat;
    logic                      o_out_valid;
    logic                      i_out_stall;
    ksa_pkg::t_out_beat        o_out_beat;

    // Slot pool model
    logic [KEY_W-1:0]               owner_key [ksa_pkg::POOL_DEPTH];
    logic [ksa_pkg::POOL_DEPTH-1:0] held;
    logic [ksa_pkg::POOL_DEPTH-1:0] marked;
    logic [ksa_pkg::CFG_W-1:0]      size_shadow;
    ksa_pkg::t_out_beat             pending_responses [$];

    logic [KEY_W-1:0] key_set [KEY_SET];
    int fails;
    int items_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;

    t_plan_row plan [N_PLAN] = '{
        // pool size 0 after reset: everything is full or a miss
        '{1'b0, 5'd0, '{ksa_pkg::ACT_ACQUIRE, '0, 1'b0}, 1'b1,
          '{ksa_pkg::KIND_ACQUIRE, 1'b0, 4'd0, '0, 1'b0}},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_RELEASE, '1, 1'b1}, 1'b1,
          '{ksa_pkg::KIND_RELEASE, 1'b0, 4'd0, '0, 1'b0}},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_QUERY, '0, 1'b0}, 1'b1,
          '{ksa_pkg::KIND_QUERY, 1'b0, 4'd0, '0, 1'b0}},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_SWEEP, '0, 1'b0}, 1'b1,
          '{ksa_pkg::KIND_DONE, 1'b0, 4'd0, '0, 1'b1}},
        '{1'b1, 5'd3, '{ksa_pkg::ACT_ACQUIRE, '0, 1'b0}, 1'b1,
          '{ksa_pkg::KIND_ACQUIRE, 1'b1, 4'd0, '0, 1'b0}},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_ACQUIRE, '1, 1'b1}, 1'b1,
          '{ksa_pkg::KIND_ACQUIRE, 1'b1, 4'd1, '0, 1'b0}},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_ACQUIRE, '0, 1'b1}, 1'b1,
          '{ksa_pkg::KIND_ACQUIRE, 1'b1, 4'd0, '0, 1'b0}},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_ACQUIRE, 32'd5, 1'b0}, 1'b1,
          '{ksa_pkg::KIND_ACQUIRE, 1'b1, 4'd2, '0, 1'b0}},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_ACQUIRE, 32'd6, 1'b0}, 1'b1,
          '{ksa_pkg::KIND_ACQUIRE, 1'b0, 4'd0, '0, 1'b0}},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_QUERY, '1, 1'b0}, 1'b1,
          '{ksa_pkg::KIND_QUERY, 1'b1, 4'd1, '0, 1'b0}},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_QUERY, 32'd7, 1'b0}, 1'b1,
          '{ksa_pkg::KIND_QUERY, 1'b0, 4'd0, '0, 1'b0}},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_RELEASE, 32'd5, 1'b0}, 1'b1,
          '{ksa_pkg::KIND_RELEASE, 1'b1, 4'd2, '0, 1'b0}},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_RELEASE, 32'd5, 1'b0}, 1'b1,
          '{ksa_pkg::KIND_RELEASE, 1'b0, 4'd0, '0, 1'b0}},
        // list keeps key 0; key 9 is taken mid-list and unknown key 123 marks nothing
        '{1'b0, 5'd0, '{ksa_pkg::ACT_MARK, '0, 1'b0}, 1'b0, '0},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_ACQUIRE, 32'd9, 1'b0}, 1'b0, '0},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_MARK, 32'd123, 1'b1}, 1'b0, '0},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_SWEEP, '0, 1'b1}, 1'b0, '0},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_SWEEP, '1, 1'b0}, 1'b1,
          '{ksa_pkg::KIND_DONE, 1'b0, 4'd0, '0, 1'b1}},
        '{1'b0, 5'd0, '{ACT_RSVD_A, '0, 1'b0}, 1'b0, '0},
        '{1'b0, 5'd0, '{ACT_RSVD_B, '1, 1'b1}, 1'b0, '0},
        '{1'b0, 5'd0, '{ACT_RSVD_C, '0, 1'b1}, 1'b0, '0},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_MARK, '1, 1'b1}, 1'b1,
          '{ksa_pkg::KIND_DONE, 1'b0, 4'd0, '0, 1'b1}},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_ACQUIRE, 32'd11, 1'b0}, 1'b1,
          '{ksa_pkg::KIND_ACQUIRE, 1'b1, 4'd0, '0, 1'b0}},
        // oversized pool; the write must have dropped key 11
        '{1'b1, 5'd31, '{ksa_pkg::ACT_QUERY, 32'd11, 1'b0}, 1'b1,
          '{ksa_pkg::KIND_QUERY, 1'b0, 4'd0, '0, 1'b0}},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_ACQUIRE, 32'h5A5A_5A5A, 1'b0}, 1'b1,
          '{ksa_pkg::KIND_ACQUIRE, 1'b1, 4'd0, '0, 1'b0}},
        '{1'b0, 5'd0, '{ksa_pkg::ACT_SWEEP, '0, 1'b0}, 1'b0, '0}
    };

    keyed_slot_allocator_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    function automatic ksa_pkg::t_out_beat resp(logic [ksa_pkg::ACT_W-1:0] kind, logic ok,
                                                int slot, logic [KEY_W-1:0] key,
                                                logic lst);
        ksa_pkg::t_out_beat r;
        r.kind        = kind;
        r.ok          = ok;
        r.slot        = ksa_pkg::SLOT_W'(slot);
        r.evicted_key = key;
        r.last_res    = lst;
        return r;
    endfunction

    function automatic ksa_pkg::t_in_beat mk_req(logic [ksa_pkg::ACT_W-1:0] act,
                                                 logic [KEY_W-1:0] key, logic lst);
        ksa_pkg::t_in_beat b;
        b.action     = act;
        b.entity_key = key;
        b.last       = lst;
        return b;
    endfunction

    // Append one beat to the expected queue
    function automatic void add_expected(ksa_pkg::t_out_beat b);
        pending_responses = {pending_responses, b};
    endfunction

    function automatic int active_slots();
        return (size_shadow > ksa_pkg::POOL_DEPTH) ? ksa_pkg::POOL_DEPTH : int'(size_shadow);
    endfunction

    function automatic int find_owner(logic [KEY_W-1:0] key);
        int s = -1;
        for (int i = active_slots() - 1; i >= 0; i--) begin
            if (held[i] && owner_key[i] == key) s = i;
        end
        return s;
    endfunction

    function automatic int sweep_unmarked(output ksa_pkg::t_out_beat res [ksa_pkg::MAX_OUT]);
        int cnt = 0;
        for (int i = 0; i < active_slots() && cnt < ksa_pkg::MAX_OUT; i++) begin
            if (held[i] && !marked[i]) begin
                held[i]  = 1'b0;
                res[cnt] = resp(ksa_pkg::KIND_EVICT, 1'b0, i, owner_key[i], 1'b0);
                cnt++;
            end
        end
        marked = '0;
        if (cnt == 0) begin
            res[0] = resp(ksa_pkg::KIND_DONE, 1'b0, 0, '0, 1'b1);
            cnt = 1;
        end else begin
            res[cnt - 1].last_res = 1'b1;
        end
        return cnt;
    endfunction

    // Apply one request to the pool model and return the response beats it causes
    function automatic int compute_responses(input ksa_pkg::t_in_beat req,
                                             output ksa_pkg::t_out_beat res [ksa_pkg::MAX_OUT]);
        int s;
        int n = 0;
        s = find_owner(req.entity_key);
        case (req.action)
            ksa_pkg::ACT_ACQUIRE: begin
                if (s < 0) begin
                    for (int i = active_slots() - 1; i >= 0; i--) begin
                        if (!held[i]) s = i;
                    end
                    if (s >= 0) begin
                        held[s]      = 1'b1;
                        marked[s]    = 1'b0;
                        owner_key[s] = req.entity_key;
                    end
                end
                res[0] = (s >= 0) ? resp(ksa_pkg::KIND_ACQUIRE, 1'b1, s, '0, 1'b0)
                                  : resp(ksa_pkg::KIND_ACQUIRE, 1'b0, 0, '0, 1'b0);
                n = 1;
            end
            ksa_pkg::ACT_RELEASE: begin
                if (s >= 0) begin
                    held[s]   = 1'b0;
                    marked[s] = 1'b0;
                end
                res[0] = (s >= 0) ? resp(ksa_pkg::KIND_RELEASE, 1'b1, s, '0, 1'b0)
                                  : resp(ksa_pkg::KIND_RELEASE, 1'b0, 0, '0, 1'b0);
                n = 1;
            end
            ksa_pkg::ACT_QUERY: begin
                res[0] = (s >= 0) ? resp(ksa_pkg::KIND_QUERY, 1'b1, s, '0, 1'b0)
                                  : resp(ksa_pkg::KIND_QUERY, 1'b0, 0, '0, 1'b0);
                n = 1;
            end
            ksa_pkg::ACT_MARK: begin
                if (s >= 0) marked[s] = 1'b1;
                if (req.last) n = sweep_unmarked(res);
            end
            ksa_pkg::ACT_SWEEP: n = sweep_unmarked(res);
            default: n = 0;
        endcase
        return n;
    endfunction

    function automatic int field_diff(string name, logic [KEY_W-1:0] want,
                                      logic [KEY_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    function automatic logic [KEY_W-1:0] any_key();
        if ($urandom_range(9) == 0) return $urandom;
        return key_set[$urandom_range(KEY_SET - 1)];
    endfunction

    // Offer one beat, hold it until taken, then queue the table's beat or what the model predicts
    task automatic send_item(input ksa_pkg::t_in_beat req, input logic typed,
                             input ksa_pkg::t_out_beat want);
        ksa_pkg::t_out_beat res [ksa_pkg::MAX_OUT];
        int n;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n = compute_responses(req, res);
        if (typed) begin
            add_expected(want);
        end else begin
            for (int i = 0; i < n; i++) add_expected(res[i]);
        end
        if (req.action <= ksa_pkg::ACT_SWEEP) items_sent++;
    endtask

    task automatic write_pool_size(input logic [ksa_pkg::CFG_W-1:0] sz);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        // a mark beat without last may still be scanning
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= sz;
        @(posedge i_clk);
        size_shadow = sz;
        held        = '0;
        marked      = '0;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_op();
        int pick;
        int len;
        pick = $urandom_range(99);
        if (pick < 30) begin
            send_item(mk_req(ksa_pkg::ACT_ACQUIRE, any_key(), 1'($urandom_range(1))),
                      1'b0, '0);
        end else if (pick < 42) begin
            send_item(mk_req(ksa_pkg::ACT_RELEASE, any_key(), 1'($urandom_range(1))),
                      1'b0, '0);
        end else if (pick < 54) begin
            send_item(mk_req(ksa_pkg::ACT_QUERY, any_key(), 1'($urandom_range(1))),
                      1'b0, '0);
        end else if (pick < 84) begin
            len = $urandom_range(4);
            if (len == 0) begin
                send_item(mk_req(ksa_pkg::ACT_SWEEP, $urandom, 1'($urandom_range(1))),
                          1'b0, '0);
            end
            for (int i = 0; i < len; i++) begin
                // fold an acquire into the list now and then
                if ($urandom_range(99) < 15) begin
                    send_item(mk_req(ksa_pkg::ACT_ACQUIRE, any_key(), 1'b0), 1'b0, '0);
                end
                send_item(mk_req(ksa_pkg::ACT_MARK, any_key(), i == len - 1), 1'b0, '0);
            end
        end else if (pick < 92) begin
            send_item(mk_req(ksa_pkg::ACT_W'($urandom_range(ACT_RSVD_C, ACT_RSVD_A)),
                             $urandom, 1'($urandom_range(1))), 1'b0, '0);
        end else begin
            // dangling mark: merges into whatever list comes next
            send_item(mk_req(ksa_pkg::ACT_MARK, any_key(), 1'b0), 1'b0, '0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Response side: random stall, or a long hold-off when requested
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        ksa_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_responses.size() == 0) begin
                $error("response beat with nothing expected: kind %0d slot %0d",
                       o_out_beat.kind, o_out_beat.slot);
                fails++;
            end else begin
                want = pending_responses.pop_front();
                if (field_diff("kind", KEY_W'(want.kind), KEY_W'(o_out_beat.kind))
                    + field_diff("ok", KEY_W'(want.ok), KEY_W'(o_out_beat.ok))
                    + field_diff("slot", KEY_W'(want.slot), KEY_W'(o_out_beat.slot))
                    + field_diff("evicted_key", want.evicted_key, o_out_beat.evicted_key)
                    + field_diff("last_res", KEY_W'(want.last_res),
                                 KEY_W'(o_out_beat.last_res)) != 0) begin
                    fails++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int target;
        logic [ksa_pkg::CFG_W-1:0] sz;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_in_beat     = '0;
        size_shadow   = '0;
        held          = '0;
        marked        = '0;
        fails         = 0;
        items_sent    = 0;
        hold_left     = 0;
        send_idle_pct = 23;
        recv_idle_pct = 72;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].set_size) write_pool_size(plan[r].size);
            send_item(plan[r].req, plan[r].typed, plan[r].want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            send_idle_pct = (p < 2) ? 23 : (p < 4) ? 72 : 0;
            recv_idle_pct = (p < 2) ? 72 : (p < 4) ? 23 : 0;
            sz = (p == N_PHASES - 1) ? ksa_pkg::CFG_W'($urandom_range(15, 2))
                                     : PHASE_SIZES[p];
            key_set[0] = '0;
            key_set[1] = '1;
            for (int k = 2; k < KEY_SET; k++) key_set[k] = $urandom;
            write_pool_size(sz);
            if (p == 4) hold_left = HOLD_CYCLES;
            if (sz >= ksa_pkg::POOL_DEPTH) begin
                // fill every slot, overflow once, then evict the whole pool
                for (int i = 0; i <= ksa_pkg::POOL_DEPTH; i++) begin
                    send_item(mk_req(ksa_pkg::ACT_ACQUIRE, $urandom, 1'b0), 1'b0, '0);
                end
                send_item(mk_req(ksa_pkg::ACT_SWEEP, $urandom, 1'b1), 1'b0, '0);
            end
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) random_op();
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ksa_pkg.sv
rtl/ksa_ram.sv
rtl/keyed_slot_allocator_unit.sv
tb/tb_keyed_slot_allocator_unit.sv
